// ===== hw/rtl/bsf_pkg.sv =====
package bsf_pkg;

   localparam logic [7:0] FLAG_PATTERN = 8'b01111110;
   localparam int FLAG_LEN = 8;
   localparam int HELD_W = 6;
   localparam int COUNT_W = 3;
   localparam logic [COUNT_W-1:0] STUFF_RUN = 3'd5;
   localparam logic [COUNT_W-1:0] FLAG_LAST_IDX = 3'd7;
   localparam int QUEUE_DEPTH = 4;

   localparam logic DIR_TX = 1'b0;
   localparam logic DIR_RX = 1'b1;

   typedef enum logic [1:0] {
      TAIL_NONE,
      TAIL_FLAG,
      TAIL_STATUS
   } tail_type;

   typedef enum logic [1:0] {
      RX_HUNT,
      RX_DATA,
      RX_TRAIL
   } rx_phase_type;

   typedef enum logic [1:0] {
      STG_HEAD,
      STG_BITS,
      STG_TAIL
   } stage_type;

   // one accepted item expands into: an optional opening flag, up to HELD_W bits, then an optional tail
   typedef struct packed {
      logic               head_flag;
      logic [COUNT_W-1:0] bit_count;
      logic [HELD_W-1:0]  bits;
      tail_type           tail;
      logic               status_end;
      logic               status_err;
   } cmd_type;

endpackage

// ===== hw/rtl/bsf_front.sv =====
module bsf_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  logic             req_in_bit,
   input  logic             req_frame_last,
   input  logic             csr_write_enable,
   input  logic             csr_direction,
   output logic             push_valid,
   input  logic             push_ready,
   output bsf_pkg::cmd_type push_cmd
);

   logic                                direction_ff, direction_in;
   logic                                frame_open_ff, frame_open_in;
   logic [bsf_pkg::COUNT_W-1:0]         ones_run_ff, ones_run_in;
   bsf_pkg::rx_phase_type               rx_phase_ff, rx_phase_in;
   logic [bsf_pkg::COUNT_W-1:0]         header_count_ff, header_count_in;
   logic                                header_mismatch_ff, header_mismatch_in;
   logic [bsf_pkg::HELD_W-1:0]          held_bits_ff, held_bits_in;
   logic [bsf_pkg::COUNT_W-1:0]         held_count_ff, held_count_in;

   logic                                accept;
   logic [bsf_pkg::COUNT_W-1:0]         tx_base;
   logic [bsf_pkg::COUNT_W-1:0]         tx_run;
   logic                                tx_stuff;
   logic                                mismatch_now;
   logic                                run_full;
   bsf_pkg::cmd_type                    cmd;

   assign accept = req_valid & req_ready;
   assign req_ready = push_ready;
   assign push_valid = accept & (cmd.head_flag | (cmd.bit_count != '0)
                                 | (cmd.tail != bsf_pkg::TAIL_NONE));
   assign push_cmd = cmd;

   assign tx_base = frame_open_ff ? ones_run_ff : '0;
   assign tx_run = req_in_bit ? tx_base + 3'd1 : '0;
   assign tx_stuff = tx_run >= bsf_pkg::STUFF_RUN;
   assign mismatch_now = header_mismatch_ff
                         | (req_in_bit != bsf_pkg::FLAG_PATTERN[header_count_ff]);
   assign run_full = ones_run_ff >= bsf_pkg::STUFF_RUN;

   // receive phase sequencing
   always_comb begin
      rx_phase_in = rx_phase_ff;
      if (direction_ff == bsf_pkg::DIR_RX) begin
         case (rx_phase_ff)
            bsf_pkg::RX_DATA: begin
               if (run_full && req_in_bit) begin
                  rx_phase_in = bsf_pkg::RX_TRAIL;
               end
            end
            bsf_pkg::RX_TRAIL: begin
               rx_phase_in = bsf_pkg::RX_HUNT;
            end
            default: begin
               if (header_count_ff == bsf_pkg::FLAG_LAST_IDX) begin
                  rx_phase_in = bsf_pkg::RX_DATA;
               end
            end
         endcase
      end
   end

   // command and datapath state
   always_comb begin
      cmd = '0;
      cmd.tail = bsf_pkg::TAIL_NONE;
      frame_open_in = frame_open_ff;
      ones_run_in = ones_run_ff;
      header_count_in = header_count_ff;
      header_mismatch_in = header_mismatch_ff;
      held_bits_in = held_bits_ff;
      held_count_in = held_count_ff;
      if (direction_ff == bsf_pkg::DIR_TX) begin
         cmd.head_flag = ~frame_open_ff;
         if (tx_stuff) begin
            cmd.bit_count = 3'd2;
            cmd.bits = {4'b0, req_in_bit, 1'b0};
         end else begin
            cmd.bit_count = 3'd1;
            cmd.bits = {5'b0, req_in_bit};
         end
         cmd.tail = req_frame_last ? bsf_pkg::TAIL_FLAG : bsf_pkg::TAIL_NONE;
         frame_open_in = ~req_frame_last;
         ones_run_in = (req_frame_last | tx_stuff) ? '0 : tx_run;
      end else begin
         case (rx_phase_ff)
            bsf_pkg::RX_DATA: begin
               if (run_full) begin
                  if (!req_in_bit) begin
                     // stuffed zero dropped, held bits are payload
                     cmd.bits = held_bits_ff;
                     cmd.bit_count = held_count_ff;
                  end else begin
                     cmd.tail = bsf_pkg::TAIL_STATUS;
                     cmd.status_end = 1'b1;
                  end
                  held_bits_in = '0;
                  held_count_in = '0;
                  ones_run_in = '0;
               end else if (req_in_bit) begin
                  ones_run_in = ones_run_ff + 3'd1;
                  if (held_count_ff != '0) begin
                     held_bits_in = {held_bits_ff[bsf_pkg::HELD_W-2:0], 1'b1};
                     held_count_in = held_count_ff + 3'd1;
                  end else begin
                     cmd.bit_count = 3'd1;
                     cmd.bits = {5'b0, 1'b1};
                  end
               end else begin
                  cmd.bits = held_bits_ff;
                  cmd.bit_count = held_count_ff;
                  held_bits_in = '0;
                  held_count_in = 3'd1;
                  ones_run_in = '0;
               end
            end
            bsf_pkg::RX_TRAIL: begin
               header_count_in = '0;
               header_mismatch_in = 1'b0;
            end
            default: begin
               if (header_count_ff == bsf_pkg::FLAG_LAST_IDX) begin
                  cmd.tail = bsf_pkg::TAIL_STATUS;
                  cmd.status_err = mismatch_now;
                  header_count_in = '0;
                  header_mismatch_in = 1'b0;
                  ones_run_in = '0;
                  held_bits_in = '0;
                  held_count_in = '0;
               end else begin
                  header_count_in = header_count_ff + 3'd1;
                  header_mismatch_in = mismatch_now;
               end
            end
         endcase
      end
   end

   assign direction_in = csr_direction;

   always_ff @(posedge clock) begin
      if (reset || csr_write_enable) begin
         direction_ff <= reset ? bsf_pkg::DIR_TX : direction_in;
         frame_open_ff <= 1'b0;
         ones_run_ff <= '0;
         rx_phase_ff <= bsf_pkg::RX_HUNT;
         header_count_ff <= '0;
         header_mismatch_ff <= 1'b0;
         held_bits_ff <= '0;
         held_count_ff <= '0;
      end else if (accept) begin
         frame_open_ff <= frame_open_in;
         ones_run_ff <= ones_run_in;
         rx_phase_ff <= rx_phase_in;
         header_count_ff <= header_count_in;
         header_mismatch_ff <= header_mismatch_in;
         held_bits_ff <= held_bits_in;
         held_count_ff <= held_count_in;
      end
   end

endmodule

// ===== hw/rtl/bsf_queue.sv =====
module bsf_queue #(
   parameter int DEPTH = bsf_pkg::QUEUE_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   output logic             push_ready,
   input  bsf_pkg::cmd_type push_cmd,
   output logic             pop_valid,
   input  logic             pop_ready,
   output bsf_pkg::cmd_type pop_cmd
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

   bsf_pkg::cmd_type     entries_ff [DEPTH];
   logic [PTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic                 do_push;
   logic                 do_pop;

   assign push_ready = count_ff != CNT_FULL;
   assign pop_valid = count_ff != '0;
   assign pop_cmd = entries_ff[rd_ptr_ff];
   assign do_push = push_valid & push_ready;
   assign do_pop = pop_valid & pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

// ===== hw/rtl/bsf_back.sv =====
module bsf_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             pop_valid,
   output logic             pop_ready,
   input  bsf_pkg::cmd_type pop_cmd,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output logic             rsp_out_bit,
   output logic             rsp_bit_valid,
   output logic             rsp_frame_end,
   output logic             rsp_flag_error,
   output logic             rsp_last
);

   logic                          active_ff, active_in;
   bsf_pkg::cmd_type              cmd_ff;
   bsf_pkg::stage_type            stage_ff, stage_in;
   logic [bsf_pkg::COUNT_W-1:0]   idx_ff, idx_in;

   logic                          rsp_valid_ff;
   logic                          out_bit_ff, out_bit_in;
   logic                          bit_valid_ff, bit_valid_in;
   logic                          frame_end_ff, frame_end_in;
   logic                          flag_error_ff, flag_error_in;
   logic                          last_ff;

   bsf_pkg::cmd_type              cur_cmd;
   bsf_pkg::stage_type            cur_stage;
   logic [bsf_pkg::COUNT_W-1:0]   cur_idx;
   bsf_pkg::stage_type            start_stage;
   logic [bsf_pkg::COUNT_W-1:0]   start_idx;
   logic                          slot_free;
   logic                          advance;
   logic                          done;

   assign slot_free = ~rsp_valid_ff | rsp_ready;
   assign advance = slot_free & (active_ff | pop_valid);
   assign pop_ready = slot_free & ~active_ff;
   assign cur_cmd = active_ff ? cmd_ff : pop_cmd;

   always_comb begin
      if (pop_cmd.head_flag) begin
         start_stage = bsf_pkg::STG_HEAD;
         start_idx = '0;
      end else if (pop_cmd.bit_count != '0) begin
         start_stage = bsf_pkg::STG_BITS;
         start_idx = pop_cmd.bit_count - 3'd1;
      end else begin
         start_stage = bsf_pkg::STG_TAIL;
         start_idx = '0;
      end
   end

   assign cur_stage = active_ff ? stage_ff : start_stage;
   assign cur_idx = active_ff ? idx_ff : start_idx;

   // next position within the command
   always_comb begin
      stage_in = cur_stage;
      idx_in = cur_idx;
      done = 1'b0;
      case (cur_stage)
         bsf_pkg::STG_HEAD: begin
            if (cur_idx == bsf_pkg::FLAG_LAST_IDX) begin
               if (cur_cmd.bit_count != '0) begin
                  stage_in = bsf_pkg::STG_BITS;
                  idx_in = cur_cmd.bit_count - 3'd1;
               end else if (cur_cmd.tail != bsf_pkg::TAIL_NONE) begin
                  stage_in = bsf_pkg::STG_TAIL;
                  idx_in = '0;
               end else begin
                  done = 1'b1;
               end
            end else begin
               idx_in = cur_idx + 3'd1;
            end
         end
         bsf_pkg::STG_BITS: begin
            if (cur_idx == '0) begin
               if (cur_cmd.tail != bsf_pkg::TAIL_NONE) begin
                  stage_in = bsf_pkg::STG_TAIL;
               end else begin
                  done = 1'b1;
               end
            end else begin
               idx_in = cur_idx - 3'd1;
            end
         end
         bsf_pkg::STG_TAIL: begin
            if (cur_cmd.tail == bsf_pkg::TAIL_FLAG
                && cur_idx != bsf_pkg::FLAG_LAST_IDX) begin
               idx_in = cur_idx + 3'd1;
            end else begin
               done = 1'b1;
            end
         end
         default: begin
            done = 1'b1;
         end
      endcase
   end

   // result for the current position
   always_comb begin
      out_bit_in = 1'b0;
      bit_valid_in = 1'b0;
      frame_end_in = 1'b0;
      flag_error_in = 1'b0;
      case (cur_stage)
         bsf_pkg::STG_HEAD: begin
            out_bit_in = bsf_pkg::FLAG_PATTERN[cur_idx];
            bit_valid_in = 1'b1;
         end
         bsf_pkg::STG_BITS: begin
            out_bit_in = cur_cmd.bits[cur_idx];
            bit_valid_in = 1'b1;
         end
         bsf_pkg::STG_TAIL: begin
            if (cur_cmd.tail == bsf_pkg::TAIL_FLAG) begin
               out_bit_in = bsf_pkg::FLAG_PATTERN[cur_idx];
               bit_valid_in = 1'b1;
               frame_end_in = cur_idx == bsf_pkg::FLAG_LAST_IDX;
            end else begin
               frame_end_in = cur_cmd.status_end;
               flag_error_in = cur_cmd.status_err;
            end
         end
         default: begin
            out_bit_in = 1'b0;
         end
      endcase
   end

   assign active_in = advance ? ~done : active_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         stage_ff <= bsf_pkg::STG_HEAD;
         idx_ff <= '0;
      end else begin
         active_ff <= active_in;
         if (advance) begin
            rsp_valid_ff <= 1'b1;
            stage_ff <= stage_in;
            idx_ff <= idx_in;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance && !active_ff) begin
         cmd_ff <= pop_cmd;
      end
      if (advance) begin
         out_bit_ff <= out_bit_in;
         bit_valid_ff <= bit_valid_in;
         frame_end_ff <= frame_end_in;
         flag_error_ff <= flag_error_in;
         last_ff <= done;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_out_bit = out_bit_ff;
   assign rsp_bit_valid = bit_valid_ff;
   assign rsp_frame_end = frame_end_ff;
   assign rsp_flag_error = flag_error_ff;
   assign rsp_last = last_ff;

endmodule

// ===== hw/rtl/bit_stuffing_framer_top.sv =====
// HDLC-style bit stuffing framer/deframer, at most one bit per transfer on each side.
// csr_direction 0 frames (opening flag, zero after five ones, closing flag
// after the bit marked frame_last); 1 deframes (opening flag check reported in
// a status result, stuffed zeros removed, closing flag reported with
// frame_end). A csr write also clears all framing state; write only when idle.
// The front end takes one input bit per cycle while the queue has room and
// pushes a command into a QUEUE_DEPTH-entry queue; the back end sends one
// result per cycle while rsp_ready is high, starting the next command only
// after the last result of the current one. Results per item: 1 for a plain
// bit, 2 with a stuffed zero, up to 17 for a one-bit transmit frame, 0-6 rx.
module bit_stuffing_framer_top #(
   parameter int QUEUE_DEPTH = bsf_pkg::QUEUE_DEPTH
) (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_ready,
   input  logic req_in_bit,
   input  logic req_frame_last,
   output logic rsp_valid,
   input  logic rsp_ready,
   output logic rsp_out_bit,
   output logic rsp_bit_valid,
   output logic rsp_frame_end,
   output logic rsp_flag_error,
   output logic rsp_last,
   input  logic csr_write_enable,
   input  logic csr_direction
);

   logic             push_valid;
   logic             push_ready;
   bsf_pkg::cmd_type push_cmd;
   logic             pop_valid;
   logic             pop_ready;
   bsf_pkg::cmd_type pop_cmd;

   bsf_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_in_bit       (req_in_bit),
      .req_frame_last   (req_frame_last),
      .csr_write_enable (csr_write_enable),
      .csr_direction    (csr_direction),
      .push_valid       (push_valid),
      .push_ready       (push_ready),
      .push_cmd         (push_cmd)
   );

   bsf_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_cmd   (push_cmd),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_cmd    (pop_cmd)
   );

   bsf_back u_back (
      .clock          (clock),
      .reset          (reset),
      .pop_valid      (pop_valid),
      .pop_ready      (pop_ready),
      .pop_cmd        (pop_cmd),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_out_bit    (rsp_out_bit),
      .rsp_bit_valid  (rsp_bit_valid),
      .rsp_frame_end  (rsp_frame_end),
      .rsp_flag_error (rsp_flag_error),
      .rsp_last       (rsp_last)
   );

endmodule

// ===== sim/bsf_checker.sv =====
module bsf_checker (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   input  logic req_ready,
   input  logic req_in_bit,
   input  logic req_frame_last,
   input  logic rsp_valid,
   input  logic rsp_ready,
   input  logic rsp_out_bit,
   input  logic rsp_bit_valid,
   input  logic rsp_frame_end,
   input  logic rsp_flag_error,
   input  logic rsp_last,
   input  logic csr_write_enable,
   input  logic csr_direction,
   output int   error_count,
   output int   expected_count
);

   typedef struct packed {
      logic out_bit;
      logic bit_valid;
      logic frame_end;
      logic flag_error;
      logic last;
   } line_result_type;

   line_result_type expected_results[$];
   line_result_type item_results[$];
   line_result_type want_result;
   int              results_seen = 0;

   logic                        dir_mode;
   logic                        frame_open;
   logic [bsf_pkg::COUNT_W-1:0] ones_run;
   bsf_pkg::rx_phase_type       rx_phase;
   logic [bsf_pkg::COUNT_W-1:0] header_count;
   logic                        header_mismatch;
   logic [bsf_pkg::HELD_W-1:0]  held_bits;
   logic [bsf_pkg::COUNT_W-1:0] held_count;

   task automatic report_error(input string msg);
      error_count++;
      $display("%0t checker: %s", $time, msg);
   endtask

   task automatic check_field(input string name, input logic got, input logic want);
      if (got !== want)
         report_error($sformatf("result %0d: %s got %b, want %b",
                                results_seen, name, got, want));
   endtask

   task automatic clear_framing();
      frame_open = 1'b0;
      ones_run = '0;
      rx_phase = bsf_pkg::RX_HUNT;
      header_count = '0;
      header_mismatch = 1'b0;
      held_bits = '0;
      held_count = '0;
   endtask

   task automatic emit(input logic b, input logic v, input logic fe, input logic er);
      line_result_type r;
      r.out_bit = v & b;
      r.bit_valid = v;
      r.frame_end = fe;
      r.flag_error = er;
      r.last = 1'b0;
      item_results = {item_results, r};
   endtask

   task automatic release_held();
      for (int i = held_count; i > 0; i--)
         emit(held_bits[i-1], 1'b1, 1'b0, 1'b0);
      held_bits = '0;
      held_count = '0;
   endtask

   task automatic frame_tx(input logic b, input logic fl);
      if (!frame_open) begin
         for (int i = 0; i < bsf_pkg::FLAG_LEN; i++)
            emit(bsf_pkg::FLAG_PATTERN[bsf_pkg::FLAG_LEN-1-i], 1'b1, 1'b0, 1'b0);
         frame_open = 1'b1;
         ones_run = '0;
      end
      emit(b, 1'b1, 1'b0, 1'b0);
      ones_run = b ? ones_run + 3'd1 : 3'd0;
      // zero inserted after five ones, also at the end of a frame
      if (ones_run >= bsf_pkg::STUFF_RUN) begin
         emit(1'b0, 1'b1, 1'b0, 1'b0);
         ones_run = '0;
      end
      if (fl) begin
         for (int i = 0; i < bsf_pkg::FLAG_LEN; i++)
            emit(bsf_pkg::FLAG_PATTERN[bsf_pkg::FLAG_LEN-1-i], 1'b1,
                 i == bsf_pkg::FLAG_LAST_IDX, 1'b0);
         frame_open = 1'b0;
         ones_run = '0;
      end
   endtask

   task automatic deframe_rx(input logic b);
      case (rx_phase)
         bsf_pkg::RX_DATA: begin
            if (ones_run >= bsf_pkg::STUFF_RUN) begin
               if (!b) begin
                  release_held();
                  ones_run = '0;
               end else begin
                  // sixth one: closing flag, held flag bits dropped
                  held_bits = '0;
                  held_count = '0;
                  ones_run = '0;
                  rx_phase = bsf_pkg::RX_TRAIL;
                  emit(1'b0, 1'b0, 1'b1, 1'b0);
               end
            end else if (b) begin
               ones_run = ones_run + 3'd1;
               if (held_count > 0) begin
                  held_bits = {held_bits[bsf_pkg::HELD_W-2:0], 1'b1};
                  held_count = held_count + 3'd1;
               end else begin
                  emit(1'b1, 1'b1, 1'b0, 1'b0);
               end
            end else begin
               release_held();
               held_count = 3'd1;
               ones_run = '0;
            end
         end
         bsf_pkg::RX_TRAIL: begin
            rx_phase = bsf_pkg::RX_HUNT;
            header_count = '0;
            header_mismatch = 1'b0;
         end
         default: begin
            if (b != bsf_pkg::FLAG_PATTERN[bsf_pkg::FLAG_LEN-1-header_count])
               header_mismatch = 1'b1;
            if (header_count == bsf_pkg::FLAG_LAST_IDX) begin
               emit(1'b0, 1'b0, 1'b0, header_mismatch);
               rx_phase = bsf_pkg::RX_DATA;
               header_count = '0;
               header_mismatch = 1'b0;
               ones_run = '0;
               held_bits = '0;
               held_count = '0;
            end else begin
               header_count = header_count + 3'd1;
            end
         end
      endcase
   endtask

   task automatic predict_item(input logic b, input logic fl);
      item_results.delete();
      if (dir_mode == bsf_pkg::DIR_TX)
         frame_tx(b, fl);
      else
         deframe_rx(b);
      if (item_results.size() > 0)
         item_results[item_results.size()-1].last = 1'b1;
      expected_results = {expected_results, item_results};
   endtask

   always @(posedge clock) begin
      if (reset) begin
         expected_results.delete();
         dir_mode = bsf_pkg::DIR_TX;
         clear_framing();
      end else begin
         if (csr_write_enable) begin
            dir_mode = csr_direction;
            clear_framing();
         end
         if (req_valid && req_ready)
            predict_item(req_in_bit, req_frame_last);
         if (rsp_valid && rsp_ready) begin
            if (expected_results.size() == 0) begin
               report_error($sformatf("result %0d: transfer with nothing expected",
                                      results_seen));
            end else begin
               want_result = expected_results.pop_front();
               check_field("out_bit", rsp_out_bit, want_result.out_bit);
               check_field("bit_valid", rsp_bit_valid, want_result.bit_valid);
               check_field("frame_end", rsp_frame_end, want_result.frame_end);
               check_field("flag_error", rsp_flag_error, want_result.flag_error);
               check_field("last", rsp_last, want_result.last);
            end
            results_seen++;
         end
      end
      expected_count = expected_results.size();
   end

endmodule

// ===== sim/tb_top.sv =====
module tb_top;

   localparam int SETTLE_CYCLES = 32;
   localparam int HOLD_CYCLES = 300;
   localparam int PHASE_ITEMS = 8;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_in_bit = 1'b0;
   logic req_frame_last = 1'b0;
   logic rsp_ready = 1'b0;
   logic csr_write_enable = 1'b0;
   logic csr_direction = 1'b0;
   logic hold_rx = 1'b0;

   logic req_ready;
   logic rsp_valid;
   logic rsp_out_bit;
   logic rsp_bit_valid;
   logic rsp_frame_end;
   logic rsp_flag_error;
   logic rsp_last;

   int error_count;
   int expected_count;
   int idle_pct = 0;
   int stall_pct = 0;
   int items_sent = 0;

   bit_stuffing_framer_top u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_in_bit       (req_in_bit),
      .req_frame_last   (req_frame_last),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_out_bit      (rsp_out_bit),
      .rsp_bit_valid    (rsp_bit_valid),
      .rsp_frame_end    (rsp_frame_end),
      .rsp_flag_error   (rsp_flag_error),
      .rsp_last         (rsp_last),
      .csr_write_enable (csr_write_enable),
      .csr_direction    (csr_direction)
   );

   bsf_checker u_checker (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_in_bit       (req_in_bit),
      .req_frame_last   (req_frame_last),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_out_bit      (rsp_out_bit),
      .rsp_bit_valid    (rsp_bit_valid),
      .rsp_frame_end    (rsp_frame_end),
      .rsp_flag_error   (rsp_flag_error),
      .rsp_last         (rsp_last),
      .csr_write_enable (csr_write_enable),
      .csr_direction    (csr_direction),
      .error_count      (error_count),
      .expected_count   (expected_count)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   initial begin
      #2_000_000;
      $display("[FAIL] regression broken");
      $finish;
   end

   always @(negedge clock) begin
      rsp_ready <= !hold_rx && ($urandom_range(0, 99) >= stall_pct);
   end

   task automatic send_bit(input logic data_bit, input logic last_mark);
      @(negedge clock);
      while ($urandom_range(0, 99) < idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_in_bit <= data_bit;
      req_frame_last <= last_mark;
      do @(posedge clock); while (!req_ready);
      items_sent++;
   endtask

   task automatic wait_idle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_count != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_direction(input logic dir);
      wait_idle();
      csr_write_enable <= 1'b1;
      csr_direction <= dir;
      @(negedge clock);
      csr_write_enable <= 1'b0;
   endtask

   // payload bits lean toward ones so runs of five show up often
   task automatic send_tx_frame();
      int len;
      len = $urandom_range(1, 12);
      for (int i = 0; i < len; i++)
         send_bit($urandom_range(0, 3) != 0, i == len - 1 || $urandom_range(0, 31) == 0);
   endtask

   // well-formed line frame, sometimes with a bad opening flag or trailing bit
   task automatic send_rx_frame();
      logic [7:0] open_flag;
      logic [7:0] close_flag;
      logic       b;
      int         len;
      int         run;
      open_flag = bsf_pkg::FLAG_PATTERN;
      close_flag = bsf_pkg::FLAG_PATTERN;
      if ($urandom_range(0, 4) == 0)
         open_flag = open_flag ^ (8'b1 << $urandom_range(0, 7));
      if ($urandom_range(0, 5) == 0)
         close_flag[0] = 1'b1;
      for (int i = bsf_pkg::FLAG_LEN - 1; i >= 0; i--)
         send_bit(open_flag[i], $urandom_range(0, 1));
      len = $urandom_range(0, 10);
      run = 0;
      for (int i = 0; i < len; i++) begin
         b = $urandom_range(0, 3) != 0;
         send_bit(b, $urandom_range(0, 1));
         run = b ? run + 1 : 0;
         if (run == 5) begin
            send_bit(1'b0, $urandom_range(0, 1));
            run = 0;
         end
      end
      for (int i = bsf_pkg::FLAG_LEN - 1; i >= 0; i--)
         send_bit(close_flag[i], $urandom_range(0, 1));
   endtask

   task automatic send_noise();
      int len;
      len = $urandom_range(6, 12);
      repeat (len) send_bit($urandom_range(0, 1), $urandom_range(0, 1));
   endtask

   initial begin
      logic [20:0] rx_line;
      int          phase_start;
      logic        dir;
      // good flag, five ones and a stuffed zero, six ones, trailing one
      rx_line = 21'b01111110_111110_111111_1;

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      write_direction(bsf_pkg::DIR_TX);
      for (int i = 0; i < 5; i++)
         send_bit(1'b1, i == 4);
      send_bit(1'b0, 1'b1);
      send_bit(1'b1, 1'b1);

      write_direction(bsf_pkg::DIR_RX);
      for (int i = 20; i >= 0; i--)
         send_bit(rx_line[i], $urandom_range(0, 1));

      for (int p = 0; p < 8; p++) begin
         dir = (p % 2 == 1) ? bsf_pkg::DIR_RX : bsf_pkg::DIR_TX;
         write_direction(dir);
         case (p / 2)
            0: begin idle_pct = 0;  stall_pct <= 0;  end
            1: begin idle_pct = 64; stall_pct <= 0;  end
            2: begin idle_pct = 0;  stall_pct <= 64; end
            default: begin idle_pct = 8; stall_pct <= 8; end
         endcase
         phase_start = items_sent;
         if (p == 0) begin
            // long receiver hold-off while the sender keeps offering
            fork
               begin
                  hold_rx <= 1'b1;
                  repeat (HOLD_CYCLES) @(negedge clock);
                  hold_rx <= 1'b0;
               end
               repeat (4) send_tx_frame();
            join
         end
         while (items_sent - phase_start < PHASE_ITEMS) begin
            if (p == 5 && items_sent - phase_start >= PHASE_ITEMS / 2 &&
                items_sent - phase_start < PHASE_ITEMS / 2 + 1)
               wait_idle();
            if (dir == bsf_pkg::DIR_TX)
               send_tx_frame();
            else
               send_rx_frame();
         end
         if (dir == bsf_pkg::DIR_RX)
            send_noise();
      end

      @(negedge clock);
      req_valid <= 1'b0;
      stall_pct <= 0;
      while (expected_count != 0)
         @(negedge clock);
      repeat (40) @(negedge clock);
      if (error_count == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule
